[design/tcw_pkg.sv]
// shared constants, types and codes for the text console writer
`default_nettype none

package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int CELL_AW = $clog2(CELLS);
    localparam int ROW_W   = (ROWS > 2) ? $clog2(ROWS) : 1;
    localparam int COL_W   = (COLUMNS > 2) ? $clog2(COLUMNS) : 1;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int ADDR_W  = 11;
    localparam int POS_W   = 11;
    localparam int CELL_W  = CHAR_W + COLOR_W;

    // character codes and colors
    localparam logic [CHAR_W-1:0]  CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  CODE_BLANK     = 8'd32;
    localparam logic [COLOR_W-1:0] COLOR_AT_RESET = 8'd15;

    // queues between front, back and result side
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PW    = (CMDQ_DEPTH > 2) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_PW    = (RESQ_DEPTH > 2) ? $clog2(RESQ_DEPTH) : 1;
    localparam int RESQ_CW    = $clog2(RESQ_DEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_READ  = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_PUT,
        OP_NEWLINE,
        OP_BACKSPACE,
        OP_CLEAR,
        OP_READ
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t              op;
        logic [CHAR_W-1:0]    ch;
        logic [COLOR_W-1:0]   color;
        logic [CELL_AW-1:0]   addr;
    } cmd_t;

    typedef struct packed {
        logic [POS_W-1:0]   pos;
        logic [CHAR_W-1:0]  rch;
        logic [COLOR_W-1:0] rcol;
    } result_t;

    typedef struct packed {
        logic init_busy;
        logic res_push;
        logic res_full;
    } back_stat_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_SCROLL,
        ST_BLANK,
        ST_DONE
    } back_state_t;

endpackage

`default_nettype wire

[design/text_console_writer.sv]
// top level of the text console writer: front end, back end and assertions
// put, newline, backspace and out-of-range read go from ST_IDLE to ST_DONE, where the result
//   is queued; an in-range read passes ST_READ between them, a scroll ST_SCROLL and ST_BLANK,
//   a clear ST_CLEAR; the scroll and clear sweeps are set by the single store write port
// the back sequencer takes a new command only in ST_IDLE, so one item is through before the next starts
// reset: cursor to home, default color 15, then a pass over all ROWS*COLUMNS cells blanks
//   the screen store while full stays high; config writes are taken throughout
`default_nettype none

module text_console_writer import tcw_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input queue side
    input  wire logic               push,
    output      logic               full,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [CHAR_W-1:0]  char_code,
    input  wire logic [COLOR_W-1:0] char_color,
    input  wire logic [ADDR_W-1:0]  cell_address,
    // result queue side
    output      logic               empty,
    input  wire logic               pop,
    output      logic [POS_W-1:0]   cursor_position,
    output      logic [CHAR_W-1:0]  read_char,
    output      logic [COLOR_W-1:0] read_color,
    // default color register write channel
    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic [COLOR_W-1:0] default_color
);

    // commands classified by the front end wait in a short queue
    logic       cmd_valid;
    cmd_t       cmd;
    logic       cmd_take;
    back_stat_t stat;
    result_t    result;

    // front end: decodes func and char code into a command per transaction
    tcw_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .char_code    (char_code),
        .char_color   (char_color),
        .cell_address (cell_address),
        .stat         (stat),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_take     (cmd_take)
    );

    // back end: owns the cursor and screen store, runs scroll and clear sweeps
    tcw_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_take      (cmd_take),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .default_color (default_color),
        .empty         (empty),
        .pop           (pop),
        .result        (result),
        .stat          (stat)
    );

    // oldest waiting result
    assign cursor_position = result.pos;
    assign read_char       = result.rch;
    assign read_color      = result.rcol;

    // no transaction is taken while the reset pass blanks the store
    a_init_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        stat.init_busy |-> full
    ) else $error("input accepted during store clearing pass");

    // the back end only starts a command when the result queue has room
    a_result_no_overflow: assert property (
        @(posedge clk) disable iff (!rst_n)
        stat.res_push |-> !stat.res_full
    ) else $error("result queue overflow");

    // nothing starts while the reset pass runs
    a_no_take_in_init: assert property (
        @(posedge clk) disable iff (!rst_n)
        stat.init_busy |-> !cmd_take
    ) else $error("command taken during store clearing pass");

    // a waiting result always shows a cursor on the screen
    a_cursor_on_screen: assert property (
        @(posedge clk) disable iff (!rst_n)
        !empty |-> (32'(cursor_position) < 32'(CELLS))
    ) else $error("cursor position beyond the screen");

endmodule

`default_nettype wire

[design/tcw_ram.sv]
// generic simple dual-port ram with registered read
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

[design/tcw_front.sv]
// front end: accepts items, classifies them and queues commands
`default_nettype none

module tcw_front import tcw_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output      logic               full,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [CHAR_W-1:0]  char_code,
    input  wire logic [COLOR_W-1:0] char_color,
    input  wire logic [ADDR_W-1:0]  cell_address,
    input  wire back_stat_t         stat,
    output      logic               cmd_valid,
    output      cmd_t               cmd,
    input  wire logic               cmd_take
);

    cmd_t                q_mem_reg [CMDQ_DEPTH];
    logic [CMDQ_PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CW-1:0]  count_reg, count_next;
    cmd_t                cmd_in;
    logic                addr_ok;
    logic                push_ok;
    logic                take_ok;

    // classification
    assign addr_ok = 32'(cell_address) < 32'(CELLS);

    always_comb
    begin
        cmd_in.op    = OP_NOP;
        cmd_in.ch    = char_code;
        cmd_in.color = char_color;
        cmd_in.addr  = CELL_AW'(cell_address);
        case (func_t'(func))
            FUNC_PUT:
            begin
                if (char_code == CODE_NEWLINE)
                begin
                    cmd_in.op = OP_NEWLINE;
                end
                else if (char_code == CODE_BACKSPACE)
                begin
                    cmd_in.op = OP_BACKSPACE;
                end
                else
                begin
                    cmd_in.op = OP_PUT;
                end
            end
            FUNC_CLEAR:
            begin
                cmd_in.op = OP_CLEAR;
            end
            FUNC_READ:
            begin
                // a read beyond the screen behaves as a no-op
                cmd_in.op = addr_ok ? OP_READ : OP_NOP;
            end
            default:
            begin
                cmd_in.op = OP_NOP;
            end
        endcase
    end

    // command queue
    assign full      = (count_reg == CMDQ_CW'(CMDQ_DEPTH)) || stat.init_busy;
    assign push_ok   = push && !full;
    assign cmd_valid = (count_reg != '0);
    assign take_ok   = cmd_take && cmd_valid;
    assign cmd       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        end
        if (take_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        end
        if (push_ok && !take_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (take_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

[design/tcw_back.sv]
// back end: cursor, screen store sequencer and result queue
`default_nettype none

module tcw_back import tcw_pkg::*; (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    input  wire cmd_t               cmd,
    output      logic               cmd_take,
    input  wire logic               cfg_valid,
    output      logic               cfg_ready,
    input  wire logic [COLOR_W-1:0] default_color,
    output      logic               empty,
    input  wire logic               pop,
    output      result_t            result,
    output      back_stat_t         stat
);

    back_state_t          state_reg, state_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [CELL_AW-1:0]   scan_reg, scan_next;
    logic                 copy_wr_reg, copy_wr_next;
    logic [CELL_AW-1:0]   copy_dst_reg, copy_dst_next;
    logic [CHAR_W-1:0]    rch_reg, rch_next;
    logic [COLOR_W-1:0]   rcol_reg, rcol_next;
    logic [COLOR_W-1:0]   default_color_reg;

    result_t              res_mem_reg [RESQ_DEPTH];
    logic [RESQ_PW-1:0]   res_wr_ptr_reg, res_wr_ptr_next;
    logic [RESQ_PW-1:0]   res_rd_ptr_reg, res_rd_ptr_next;
    logic [RESQ_CW-1:0]   res_count_reg, res_count_next;
    logic                 res_full;
    logic                 res_push;
    logic                 pop_ok;
    result_t              res_in;

    logic                 ram_wr_en;
    logic [CELL_AW-1:0]   ram_wr_addr;
    logic [CELL_W-1:0]    ram_wr_data;
    logic                 ram_rd_en;
    logic [CELL_AW-1:0]   ram_rd_addr;
    logic [CELL_W-1:0]    ram_q;

    logic [CELL_AW-1:0]   row_base;
    logic [CELL_AW-1:0]   cur_addr;
    logic                 at_last_col;
    logic                 at_last_row;
    logic                 start;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_q)
    );

    assign row_base    = CELL_AW'(row_reg) * CELL_AW'(COLUMNS);
    assign cur_addr    = row_base + CELL_AW'(col_reg);
    assign at_last_col = (col_reg == COL_W'(COLUMNS - 1));
    assign at_last_row = (row_reg == ROW_W'(ROWS - 1));
    assign res_full    = (res_count_reg == RESQ_CW'(RESQ_DEPTH));
    assign start       = (state_reg == ST_IDLE) && cmd_valid && !res_full;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (scan_reg == CELL_AW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.op)
                        OP_PUT:
                        begin
                            state_next = (at_last_col && at_last_row) ? ST_SCROLL : ST_DONE;
                        end
                        OP_NEWLINE:
                        begin
                            state_next = at_last_row ? ST_SCROLL : ST_DONE;
                        end
                        OP_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_CLEAR:
            begin
                if (scan_reg == CELL_AW'(CELLS - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCROLL:
            begin
                if (scan_reg == CELL_AW'(CELLS - COLUMNS - 1))
                begin
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK:
            begin
                if (!copy_wr_reg && (scan_reg == CELL_AW'(CELLS - 1)))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // cursor, sweep counter and read data
    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        scan_next     = scan_reg;
        copy_wr_next  = 1'b0;
        copy_dst_next = copy_dst_reg;
        rch_next      = rch_reg;
        rcol_next     = rcol_reg;
        case (state_reg)
            ST_INIT:
            begin
                scan_next = (scan_reg == CELL_AW'(CELLS - 1)) ? '0 : scan_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    rch_next  = '0;
                    rcol_next = '0;
                    scan_next = '0;
                    case (cmd.op)
                        OP_PUT:
                        begin
                            if (at_last_col)
                            begin
                                col_next = '0;
                                if (!at_last_row)
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            col_next = '0;
                            if (!at_last_row)
                            begin
                                row_next = row_reg + 1'b1;
                            end
                        end
                        OP_BACKSPACE:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - 1'b1;
                            end
                        end
                        OP_CLEAR:
                        begin
                            row_next = '0;
                            col_next = '0;
                        end
                        default:
                        begin
                            col_next = col_reg;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                rch_next  = ram_q[CHAR_W-1:0];
                rcol_next = ram_q[CELL_W-1:CHAR_W];
            end
            ST_CLEAR:
            begin
                scan_next = scan_reg + 1'b1;
            end
            ST_SCROLL:
            begin
                scan_next     = scan_reg + 1'b1;
                copy_wr_next  = 1'b1;
                copy_dst_next = scan_reg;
            end
            ST_BLANK:
            begin
                if (!copy_wr_reg)
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            default:
            begin
                scan_next = scan_reg;
            end
        endcase
    end

    // store port and handshake outputs
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = scan_reg;
        ram_wr_data = {default_color_reg, CODE_BLANK};
        ram_rd_en   = 1'b0;
        ram_rd_addr = cmd.addr;
        cmd_take    = 1'b0;
        res_push    = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_data = {COLOR_AT_RESET, CODE_BLANK};
            end
            ST_IDLE:
            begin
                cmd_take = start;
                if (start)
                begin
                    case (cmd.op)
                        OP_PUT:
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = cur_addr;
                            ram_wr_data = {cmd.color, cmd.ch};
                        end
                        OP_BACKSPACE:
                        begin
                            ram_wr_en   = (col_reg != '0);
                            ram_wr_addr = cur_addr - CELL_AW'(1);
                            ram_wr_data = {cmd.color, CODE_BLANK};
                        end
                        OP_READ:
                        begin
                            ram_rd_en = 1'b1;
                        end
                        default:
                        begin
                            ram_wr_en = 1'b0;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                ram_wr_en = 1'b1;
            end
            ST_SCROLL:
            begin
                // read one row ahead, write the cell fetched last cycle
                ram_rd_en   = 1'b1;
                ram_rd_addr = scan_reg + CELL_AW'(COLUMNS);
                ram_wr_en   = copy_wr_reg;
                ram_wr_addr = copy_dst_reg;
                ram_wr_data = ram_q;
            end
            ST_BLANK:
            begin
                ram_wr_en = 1'b1;
                if (copy_wr_reg)
                begin
                    ram_wr_addr = copy_dst_reg;
                    ram_wr_data = ram_q;
                end
            end
            ST_DONE:
            begin
                res_push = 1'b1;
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_INIT;
            row_reg           <= '0;
            col_reg           <= '0;
            scan_reg          <= '0;
            copy_wr_reg       <= 1'b0;
            default_color_reg <= COLOR_AT_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            row_reg     <= row_next;
            col_reg     <= col_next;
            scan_reg    <= scan_next;
            copy_wr_reg <= copy_wr_next;
            if (cfg_valid && cfg_ready)
            begin
                default_color_reg <= default_color;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        copy_dst_reg <= copy_dst_next;
        rch_reg      <= rch_next;
        rcol_reg     <= rcol_next;
    end

    assign cfg_ready = 1'b1;

    // result queue
    assign res_in.pos  = POS_W'(cur_addr);
    assign res_in.rch  = rch_reg;
    assign res_in.rcol = rcol_reg;
    assign empty       = (res_count_reg == '0);
    assign pop_ok      = pop && !empty;
    assign result      = res_mem_reg[res_rd_ptr_reg];

    always_comb
    begin
        res_wr_ptr_next = res_wr_ptr_reg;
        res_rd_ptr_next = res_rd_ptr_reg;
        res_count_next  = res_count_reg;
        if (res_push)
        begin
            res_wr_ptr_next = (res_wr_ptr_reg == RESQ_PW'(RESQ_DEPTH - 1)) ? '0
                                                                           : res_wr_ptr_reg + 1'b1;
        end
        if (pop_ok)
        begin
            res_rd_ptr_next = (res_rd_ptr_reg == RESQ_PW'(RESQ_DEPTH - 1)) ? '0
                                                                           : res_rd_ptr_reg + 1'b1;
        end
        if (res_push && !pop_ok)
        begin
            res_count_next = res_count_reg + 1'b1;
        end
        else if (pop_ok && !res_push)
        begin
            res_count_next = res_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= '0;
            res_rd_ptr_reg <= '0;
            res_count_reg  <= '0;
        end
        else
        begin
            res_wr_ptr_reg <= res_wr_ptr_next;
            res_rd_ptr_reg <= res_rd_ptr_next;
            res_count_reg  <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_mem_reg[res_wr_ptr_reg] <= res_in;
        end
    end

    assign stat.init_busy = (state_reg == ST_INIT);
    assign stat.res_push  = res_push;
    assign stat.res_full  = res_full;

endmodule

`default_nettype wire
